FILE: src/mhi_pkg.sv
// Shared constants, command and status codes, and result type for the max-heap block.
package mhi_pkg;

	localparam int CAPACITY_DEF = 1024;
	localparam int DATA_W       = 32;
	localparam int CMD_W        = 2;
	localparam int STAT_W       = 2;

	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

	localparam logic signed [DATA_W-1:0] SENTINEL = -32'sd999;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic [STAT_W-1:0]        status;
	} res_t;

endpackage

FILE: src/max_heap_insert.sv
// Top level of the max-heap block: input handshake, heap engine and output register.
//
// Binary max-heap of signed 32-bit words held 1-based in a single synchronous
// memory of CAPACITY entries, plus an element count. Every accepted input word
// yields exactly one result word. cmd insert places value at position count+1
// and sifts it up (equal values are not swapped); status 1 reports a full heap.
// cmd read returns the entry at index, -999 for index 0, or status 2 when index
// is beyond the count. cmd clear empties the heap; the unused code changes
// nothing. count always shows the element count after the item. Items are
// handled one at a time. An insert climbs at most log2(CAPACITY) levels; the
// sift walks one level per cycle, bounded by the registered read of the heap
// memory. A finished result waits in the output register while the next item
// is taken in; the engine stalls only when a second result is ready before
// the first has been taken. No clearing pass is needed after reset: positions
// above the count are never read.
module max_heap_insert import mhi_pkg::*; #(
	parameter  int CAPACITY = CAPACITY_DEF,
	localparam int CNT_W    = $clog2(CAPACITY + 1)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [CMD_W-1:0]         cmd,
	input  logic signed [DATA_W-1:0] value,
	input  logic [CNT_W-1:0]         index,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [DATA_W-1:0] read_value,
	output logic [CNT_W-1:0]         count,
	output logic [STAT_W-1:0]        status
);

	logic             core_idle;
	logic             res_valid;
	logic             res_take;
	res_t             res;
	logic [CNT_W-1:0] res_count;

	logic                     out_valid_q;
	logic signed [DATA_W-1:0] read_value_q;
	logic [CNT_W-1:0]         count_q;
	logic [STAT_W-1:0]        status_q;

	// take a new word whenever the engine is idle
	assign in_ready = core_idle;
	// output register is free when empty or being drained this cycle
	assign res_take = !out_valid_q || out_ready;

	mhi_core #(
		.CAPACITY (CAPACITY)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (in_valid && in_ready),
		.cmd       (cmd),
		.value     (value),
		.index     (index),
		.idle      (core_idle),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res),
		.res_count (res_count)
	);

	// hold a result until the consumer takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_take) begin
			read_value_q <= res.value;
			count_q      <= res_count;
			status_q     <= res.status;
		end
	end

	assign out_valid  = out_valid_q;
	assign read_value = read_value_q;
	assign count      = count_q;
	assign status     = status_q;

endmodule

FILE: src/mhi_core.sv
// Heap engine: heap memory, element count and the insert / read / clear sequencer.
module mhi_core import mhi_pkg::*; #(
	parameter  int CAPACITY = CAPACITY_DEF,
	localparam int CNT_W    = $clog2(CAPACITY + 1),
	localparam int AW       = $clog2(CAPACITY)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [CMD_W-1:0]         cmd,
	input  logic signed [DATA_W-1:0] value,
	input  logic [CNT_W-1:0]         index,
	output logic                     idle,
	output logic                     res_valid,
	input  logic                     res_take,
	output res_t                     res,
	output logic [CNT_W-1:0]         res_count
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_SIFT = 5'b00010,
		ST_FIN  = 5'b00100,
		ST_READ = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
	localparam logic [CNT_W-1:0] POS_ONE = CNT_W'(1);

	state_t                   state_q, state_d;
	logic [CNT_W-1:0]         pos_q, pos_d;
	logic [CNT_W-1:0]         count_q, count_d;
	logic signed [DATA_W-1:0] val_q, val_d;
	res_t                     res_q, res_d;

	logic signed [DATA_W-1:0] mem [CAPACITY];
	logic signed [DATA_W-1:0] rd_data_q;

	logic                     rd_en, we;
	logic [CNT_W-1:0]         rd_pos, wr_pos;
	logic [CNT_W-1:0]         rd_idx, wr_idx;
	logic signed [DATA_W-1:0] wr_data;
	logic [CNT_W-1:0]         parent, grand, new_pos;

	assign parent  = pos_q >> 1;
	assign grand   = pos_q >> 2;
	assign new_pos = count_q + POS_ONE;
	assign rd_idx  = rd_pos - POS_ONE;
	assign wr_idx  = wr_pos - POS_ONE;

	// heap memory, position p lives at address p-1
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_idx[AW-1:0]] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_idx[AW-1:0]];
		end
	end

	always_comb begin
		state_d = state_q;
		pos_d   = pos_q;
		count_d = count_q;
		val_d   = val_q;
		res_d   = res_q;
		rd_en   = 1'b0;
		rd_pos  = pos_q;
		we      = 1'b0;
		wr_pos  = pos_q;
		wr_data = val_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					res_d.value  = '0;
					res_d.status = STAT_OK;
					state_d      = ST_DONE;
					case (cmd)
						CMD_INSERT: begin
							if (count_q == CAP_CNT) begin
								res_d.status = STAT_FULL;
							end else begin
								count_d = new_pos;
								pos_d   = new_pos;
								val_d   = value;
								if (count_q == '0) begin
									// empty heap: new word is the root
									we      = 1'b1;
									wr_pos  = new_pos;
									wr_data = value;
								end else begin
									rd_en   = 1'b1;
									rd_pos  = new_pos >> 1;
									state_d = ST_SIFT;
								end
							end
						end
						CMD_READ: begin
							if (index == '0) begin
								res_d.value = SENTINEL;
							end else if (index > count_q) begin
								res_d.status = STAT_RANGE;
							end else begin
								rd_en   = 1'b1;
								rd_pos  = index;
								state_d = ST_READ;
							end
						end
						CMD_CLEAR: begin
							count_d = '0;
						end
						default: ;
					endcase
				end
			end
			ST_SIFT: begin
				// rd_data_q holds the parent of pos_q
				we = 1'b1;
				if (rd_data_q < val_q) begin
					wr_data = rd_data_q;
					pos_d   = parent;
					if (parent > POS_ONE) begin
						rd_en  = 1'b1;
						rd_pos = grand;
					end else begin
						state_d = ST_FIN;
					end
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_FIN: begin
				we      = 1'b1;
				state_d = ST_DONE;
			end
			ST_READ: begin
				res_d.value = rd_data_q;
				state_d     = ST_DONE;
			end
			ST_DONE: begin
				if (res_take) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		pos_q <= pos_d;
		val_q <= val_d;
		res_q <= res_d;
	end

	assign idle      = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_DONE);
	assign res       = res_q;
	assign res_count = count_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_CNT)
		else $error("element count above capacity");

	a_sift_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SIFT) |-> (pos_q > POS_ONE))
		else $error("sift step at the root");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(start && idle && cmd == CMD_CLEAR) |=> (count_q == '0))
		else $error("clear left elements");

	a_write_pos: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (wr_pos != '0 && wr_pos <= count_d))
		else $error("write outside the heap");

	a_done_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_take) |=> res_valid)
		else $error("result dropped before it was taken");

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for the max_heap_insert block.
`timescale 1ns / 100ps

module tb_top import mhi_pkg::*; ();

	localparam int CNT_W      = $clog2(CAPACITY_DEF + 1);
	localparam int LIMIT      = 400000;   // cycles; slowest correct run is far below
	localparam int QUIET_LO   = 3000;     // window with no idling on either side
	localparam int QUIET_HI   = 7000;
	localparam int DRAIN      = 24;       // cycles to linger after the last result

	// the one code the package leaves unnamed; the block must ignore it
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	localparam bit MIXED   = 1'b0;
	localparam bit FILLING = 1'b1;

	// one result word as the block should present it
	typedef struct packed {
		logic signed [DATA_W-1:0] rd;
		logic [CNT_W-1:0]         cnt;
		logic [STAT_W-1:0]        st;
	} heap_res_t;

	// one row of the directed sequence; want is used only when fixed is set
	typedef struct packed {
		logic [CMD_W-1:0]         op;
		logic signed [DATA_W-1:0] val;
		logic [CNT_W-1:0]         idx;
		logic                     fixed;
		heap_res_t                want;
	} dir_row_t;

	localparam heap_res_t NO_RES = '{32'sd0, 11'd0, STAT_OK};

	logic                     clk       = 1'b0;
	logic                     arst_n    = 1'b0;
	logic                     in_valid  = 1'b0;
	logic [CMD_W-1:0]         cmd       = CMD_INSERT;
	logic signed [DATA_W-1:0] value     = '0;
	logic [CNT_W-1:0]         index     = '0;
	logic                     out_ready = 1'b0;
	logic                     in_ready;
	logic                     out_valid;
	logic signed [DATA_W-1:0] read_value;
	logic [CNT_W-1:0]         count;
	logic [STAT_W-1:0]        status;

	int unsigned cycle_cnt  = 0;
	int unsigned mismatches = 0;
	logic        quiet;

	// shadow heap, 1-based like the block, and its element count
	logic signed [DATA_W-1:0] heap_mem [1:CAPACITY_DEF];
	int unsigned              heap_cnt = 0;

	// results still owed by the block, oldest first
	heap_res_t heap_expected [$];
	heap_res_t front_res;

	// Directed words: reset state, the sentinel, out-of-range reads, the unused
	// code, both extremes of value, clear, then a small heap with equal values
	// that must not swap and a late large value that must climb to the root.
	dir_row_t dir_rows [25] = '{
		'{CMD_READ,   32'sd0,          11'd0,    1'b1, '{SENTINEL,       11'd0, STAT_OK}},
		'{CMD_READ,   32'sd0,          11'd1,    1'b1, '{32'sd0,         11'd0, STAT_RANGE}},
		'{CMD_READ,   32'sh5A5A_A5A5,  11'd2047, 1'b1, '{32'sd0,         11'd0, STAT_RANGE}},
		'{CMD_UNUSED, 32'shFFFF_FFFF,  11'd2047, 1'b1, '{32'sd0,         11'd0, STAT_OK}},
		'{CMD_INSERT, 32'sh7FFF_FFFF,  11'd0,    1'b1, '{32'sd0,         11'd1, STAT_OK}},
		'{CMD_READ,   32'sd0,          11'd1,    1'b1, '{32'sh7FFF_FFFF, 11'd1, STAT_OK}},
		'{CMD_INSERT, 32'sh8000_0000,  11'd2047, 1'b1, '{32'sd0,         11'd2, STAT_OK}},
		'{CMD_READ,   32'sd0,          11'd2,    1'b1, '{32'sh8000_0000, 11'd2, STAT_OK}},
		'{CMD_READ,   32'sd0,          11'd3,    1'b1, '{32'sd0,         11'd2, STAT_RANGE}},
		'{CMD_CLEAR,  32'sd7,          11'd1,    1'b1, '{32'sd0,         11'd0, STAT_OK}},
		'{CMD_READ,   32'sd0,          11'd0,    1'b1, '{SENTINEL,       11'd0, STAT_OK}},
		'{CMD_INSERT, 32'sd5,          11'd0,    1'b0, NO_RES},
		'{CMD_INSERT, 32'sd5,          11'd0,    1'b0, NO_RES},
		'{CMD_INSERT, 32'sd5,          11'd0,    1'b0, NO_RES},
		'{CMD_INSERT, 32'sd9,          11'd0,    1'b0, NO_RES},
		'{CMD_INSERT, -32'sd1,         11'd0,    1'b0, NO_RES},
		'{CMD_INSERT, 32'sd12,         11'd0,    1'b0, NO_RES},
		'{CMD_READ,   32'sd0,          11'd1,    1'b0, NO_RES},
		'{CMD_READ,   32'sd0,          11'd2,    1'b0, NO_RES},
		'{CMD_READ,   32'sd0,          11'd3,    1'b0, NO_RES},
		'{CMD_READ,   32'sd0,          11'd4,    1'b0, NO_RES},
		'{CMD_READ,   32'sd0,          11'd6,    1'b0, NO_RES},
		'{CMD_READ,   32'sd0,          11'd7,    1'b0, NO_RES},
		'{CMD_UNUSED, 32'sd0,          11'd1,    1'b0, NO_RES},
		'{CMD_READ,   32'sd0,          11'd1,    1'b0, NO_RES}
	};

	max_heap_insert #(
		.CAPACITY(CAPACITY_DEF)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.value     (value),
		.index     (index),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.read_value(read_value),
		.count     (count),
		.status    (status)
	);

	always #10 clk = ~clk;

	assign quiet = (cycle_cnt >= QUIET_LO) && (cycle_cnt < QUIET_HI);

	// Count cycles and bail out if the block hangs.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= LIMIT) begin
			$display("tb_top: done, errors");
			$finish;
		end
	end

	// Receiver: stall at random outside the quiet window.
	always @(posedge clk) begin
		out_ready <= quiet || ($urandom_range(99) >= 22);
	end

	// Print one line per mismatch and count it.
	task automatic flag_mismatch(input string msg);
		mismatches++;
		$display("tb_top: mismatch at cycle %0d: %s", cycle_cnt, msg);
	endtask

	// Apply one accepted word to the shadow heap and return the result it owes.
	function automatic heap_res_t heap_predict(input logic [CMD_W-1:0] c,
			input logic signed [DATA_W-1:0] v, input logic [CNT_W-1:0] ix);
		heap_res_t                r;
		int unsigned              pos;
		logic signed [DATA_W-1:0] tmp;
		r.rd = '0;
		r.st = STAT_OK;
		case (c)
			CMD_INSERT: begin
				if (heap_cnt >= CAPACITY_DEF) begin
					r.st = STAT_FULL;
				end else begin
					heap_cnt++;
					heap_mem[heap_cnt] = v;
					// climb while the parent is strictly smaller; equal values stay put
					pos = heap_cnt;
					while (pos > 1 && heap_mem[pos / 2] < heap_mem[pos]) begin
						tmp                = heap_mem[pos / 2];
						heap_mem[pos / 2]  = heap_mem[pos];
						heap_mem[pos]      = tmp;
						pos                = pos / 2;
					end
				end
			end
			CMD_READ: begin
				if (ix == 0)
					r.rd = SENTINEL;
				else if (ix > heap_cnt)
					r.st = STAT_RANGE;
				else
					r.rd = heap_mem[ix];
			end
			CMD_CLEAR: heap_cnt = 0;
			default: ;
		endcase
		r.cnt = heap_cnt[CNT_W-1:0];
		return r;
	endfunction

	// Sender: idle at random, present one word, hold it until taken, then
	// record what the block owes for it.
	task automatic send_word(input logic [CMD_W-1:0] c, input logic signed [DATA_W-1:0] v,
			input logic [CNT_W-1:0] ix, input logic fixed, input heap_res_t want);
		heap_res_t r;
		while (!quiet && $urandom_range(99) < 22) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd      <= c;
		value    <= v;
		index    <= ix;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		r = heap_predict(c, v, ix);
		// a hand-written row overrides the shadow heap's answer, which still advances
		heap_expected.push_back(fixed ? want : r);
	endtask

	// Build one random word. Values lean toward extremes and a narrow band so
	// that equal values meet in the heap; reads lean toward live positions.
	task automatic random_word(input bit mode);
		logic [CMD_W-1:0]         c;
		logic signed [DATA_W-1:0] v;
		logic [CNT_W-1:0]         ix;
		int unsigned              pick;
		pick = $urandom_range(99);
		if (mode == FILLING)
			c = (pick < 95) ? CMD_INSERT : CMD_READ;
		else if (pick < 50)
			c = CMD_INSERT;
		else if (pick < 85)
			c = CMD_READ;
		else if (pick < 93)
			c = CMD_CLEAR;
		else
			c = CMD_UNUSED;

		case ($urandom_range(9))
			0:       v = 32'sh7FFF_FFFF;
			1:       v = 32'sh8000_0000;
			2, 3:    v = $signed($urandom_range(6)) - 32'sd3;
			default: v = $urandom;
		endcase

		pick = $urandom_range(99);
		if (pick < 10)
			ix = '0;
		else if (pick < 75 && heap_cnt > 0)
			ix = CNT_W'($urandom_range(heap_cnt, 1));
		else if (pick < 85)
			ix = CNT_W'(heap_cnt + 1);
		else
			ix = CNT_W'($urandom_range(2047));

		send_word(c, v, ix, 1'b0, NO_RES);
	endtask

	// Checker: every taken result word against the oldest owed one.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (heap_expected.size() == 0) begin
				flag_mismatch($sformatf("unexpected word: read_value %0d count %0d status %0d",
					read_value, count, status));
			end else begin
				front_res = heap_expected.pop_front();
				if (read_value !== front_res.rd)
					flag_mismatch($sformatf("read_value %0d, want %0d", read_value,
						front_res.rd));
				if (count !== front_res.cnt)
					flag_mismatch($sformatf("count %0d, want %0d", count, front_res.cnt));
				if (status !== front_res.st)
					flag_mismatch($sformatf("status %0d, want %0d", status, front_res.st));
			end
		end
	end

	initial begin
		// hold reset at the start, then release it once for the whole run
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed words
		foreach (dir_rows[i])
			send_word(dir_rows[i].op, dir_rows[i].val, dir_rows[i].idx,
				dir_rows[i].fixed, dir_rows[i].want);

		// random mix with clears and the unused code
		repeat (30)
			random_word(MIXED);

		// fill the heap to the brim, reading along the way
		while (heap_cnt < CAPACITY_DEF)
			random_word(FILLING);

		// push on a full heap, then probe the top edge of the index range
		repeat (6)
			send_word(CMD_INSERT, $urandom, CNT_W'($urandom_range(2047)), 1'b0, NO_RES);
		send_word(CMD_READ, $urandom, CNT_W'(CAPACITY_DEF), 1'b0, NO_RES);
		send_word(CMD_READ, $urandom, CNT_W'(CAPACITY_DEF + 1), 1'b0, NO_RES);
		send_word(CMD_READ, $urandom, 11'd2047, 1'b0, NO_RES);
		send_word(CMD_READ, $urandom, 11'd1, 1'b0, NO_RES);
		send_word(CMD_CLEAR, $urandom, CNT_W'($urandom_range(2047)), 1'b0, NO_RES);

		// rebuild from empty with the random mix
		repeat (30)
			random_word(MIXED);

		// drop valid, drain owed results, then linger to catch stray words
		in_valid <= 1'b0;
		while (heap_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);

		if (mismatches == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule

FILE: filelist.f
src/mhi_pkg.sv
src/mhi_core.sv
src/max_heap_insert.sv
sim/tb_top.sv
